### hdl/fscpa_pkg.sv
package fscpa_pkg;

   // Default image bounds of the frame store.
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   // Field widths fixed by the channel formats.
   localparam int COORD_W     = 16;
   localparam int CHAN_W      = 8;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 2;

   localparam int PIXEL_MAX     = 255;
   localparam int BYTES_PER_RGB = 3;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   typedef enum logic {
      MODE_GRAY = 1'b0,
      MODE_RGB  = 1'b1
   } color_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_COLOR_MODE   = 2'd2
   } csr_index_type;

   // Saturates a signed channel value to the byte range.
   function automatic logic [CHAN_W-1:0] sat_byte(input logic signed [COORD_W-1:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > PIXEL_MAX) begin
         return CHAN_W'(PIXEL_MAX);
      end else begin
         return v[CHAN_W-1:0];
      end
   endfunction

   // A dimension of zero counts as one, and one above the maximum as the maximum.
   function automatic int eff_dim(input logic [CSR_DATA_W-1:0] v, input int maxv);
      if (v == '0) begin
         return 1;
      end else if (int'(v) > maxv) begin
         return maxv;
      end else begin
         return int'(v);
      end
   endfunction

endpackage

### hdl/fscpa_if.sv
interface fscpa_req_if;
   logic                                     valid;
   logic                                     ready;
   fscpa_pkg::opcode_type                    opcode;
   logic signed [fscpa_pkg::COORD_W-1:0]     x_coord;
   logic signed [fscpa_pkg::COORD_W-1:0]     y_coord;
   logic signed [fscpa_pkg::COORD_W-1:0]     write_red;
   logic signed [fscpa_pkg::COORD_W-1:0]     write_green;
   logic signed [fscpa_pkg::COORD_W-1:0]     write_blue;

   modport source (output valid, opcode, x_coord, y_coord, write_red, write_green,
                   write_blue, input ready);
   modport sink   (input valid, opcode, x_coord, y_coord, write_red, write_green,
                   write_blue, output ready);
endinterface

interface fscpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [fscpa_pkg::CHAN_W-1:0]  read_red;
   logic [fscpa_pkg::CHAN_W-1:0]  read_green;
   logic [fscpa_pkg::CHAN_W-1:0]  read_blue;

   modport source (output valid, status, read_red, read_green, read_blue, input ready);
   modport sink   (input valid, status, read_red, read_green, read_blue, output ready);
endinterface

interface fscpa_csr_if;
   logic                               valid;
   logic                               ready;
   logic [fscpa_pkg::CSR_INDEX_W-1:0]  index;
   logic [fscpa_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hdl/fscpa_ram.sv
module fscpa_ram #(
   parameter int DEPTH = fscpa_pkg::MAX_WIDTH_DEF * fscpa_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [fscpa_pkg::CHAN_W-1:0]                 wdata,
   output logic [fscpa_pkg::CHAN_W-1:0]                 rdata
);

   logic [fscpa_pkg::CHAN_W-1:0] mem [DEPTH];
   logic [fscpa_pkg::CHAN_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
   end

   // Read data is held while no read is issued, so a stalled pipeline keeps it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/frame_store_clamped_pixel_access.sv
// Clamp-to-edge frame store. It holds one image of image_width by image_height
// pixels, one gray byte or three RGB bytes per pixel, in a byte store of
// MAX_WIDTH * MAX_HEIGHT * 3 bytes. A read clamps signed x and y to the nearest
// edge pixel and returns three channels (the gray byte on all three in gray
// mode); a write inside the image saturates each channel to 0..255 and stores
// it, only red in gray mode, and a write outside changes nothing. Status is 1
// whenever the coordinates fell outside. One transfer is accepted in every
// cycle while results are taken, and it then passes input register, clamp,
// address multiply, byte-address split by a reciprocal multiply, memory access
// and output register. The store is three single-port byte banks (byte address
// modulo three), so the three RGB bytes of a pixel or one gray byte are reached
// in one access; every item touches the banks in the same stage, so a read sees
// every earlier write. The store is not cleared after reset: pixels must be
// written before they are read. Configuration writes are taken at any time but
// are meant for an idle block; each result transfer holds until taken, and the
// pipeline keeps filling its empty stages while it waits.
module frame_store_clamped_pixel_access #(
   parameter int MAX_WIDTH  = fscpa_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = fscpa_pkg::MAX_HEIGHT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   fscpa_req_if.sink    req_ch,
   fscpa_rsp_if.source  rsp_ch,
   fscpa_csr_if.sink    csr_ch
);

   localparam int CW    = fscpa_pkg::CHAN_W;
   localparam int NB    = fscpa_pkg::BYTES_PER_RGB;
   localparam int NST   = 6;
   // Widths of the effective dimensions and of clamped coordinates.
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int CXW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CYW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = CYW + XW + 1;
   localparam int CMPW  = fscpa_pkg::COORD_W + 1;
   // Division by three: q = (adr * RECIP) >> RECIP_SHIFT is exact for any adr
   // below 2**ADR_W.
   localparam int RECIP_SHIFT = ADR_W + 1;
   localparam int RW    = ADR_W + 1;
   localparam int QPW   = ADR_W + RW;
   localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
   localparam logic [fscpa_pkg::CSR_DATA_W-1:0] DIM_RESET = fscpa_pkg::CSR_DATA_W'(256);

   // Configuration, stored as effective dimensions.
   logic [XW-1:0]              cfg_w_ff;
   logic [YW-1:0]              cfg_h_ff;
   fscpa_pkg::color_mode_type  cfg_mode_ff;

   // Pipeline occupancy and advance enables, one per stage.
   logic [NST-1:0] v_ff, v_in, adv;

   // Stage 0: input register.
   fscpa_pkg::opcode_type                s0_op_ff;
   logic signed [fscpa_pkg::COORD_W-1:0] s0_x_ff, s0_y_ff;
   logic signed [fscpa_pkg::COORD_W-1:0] s0_r_ff, s0_g_ff, s0_b_ff;

   // Stage 1: clamped coordinates and saturated bytes.
   fscpa_pkg::opcode_type s1_op_ff;
   logic                  s1_out_ff, s1_out_in;
   logic [CXW-1:0]        s1_cx_ff, s1_cx_in;
   logic [CYW-1:0]        s1_cy_ff, s1_cy_in;
   logic [CW-1:0]         s1_byte_ff [NB];

   // Stage 2: pixel index.
   fscpa_pkg::opcode_type s2_op_ff;
   logic                  s2_out_ff;
   logic [ADR_W-1:0]      s2_adr_ff, s2_adr_in;
   logic [CW-1:0]         s2_byte_ff [NB];
   logic [PW-1:0]         s1_prod;

   // Stage 3: bank row and bank of the gray byte.
   fscpa_pkg::opcode_type s3_op_ff;
   logic                  s3_out_ff;
   logic [ADR_W-1:0]      s3_adr_ff;
   logic [ADR_W-1:0]      s3_row_ff, s3_row_in;
   logic [1:0]            s3_rem_ff, s3_rem_in;
   logic [CW-1:0]         s3_byte_ff [NB];
   logic [QPW-1:0]        s2_qprod;

   // Stage 4: memory read data.
   fscpa_pkg::opcode_type s4_op_ff;
   logic                  s4_out_ff;
   logic [1:0]            s4_rem_ff;

   // Stage 5: output register.
   logic                  rsp_status_ff;
   logic [CW-1:0]         rsp_byte_ff [NB];
   logic [CW-1:0]         rsp_byte_in [NB];

   // Memory bank controls.
   logic [NB-1:0]         bank_we;
   logic                  bank_re;
   logic [ADR_W-1:0]      bank_addr;
   logic [CW-1:0]         bank_wdata [NB];
   logic [CW-1:0]         bank_rdata [NB];

   // ------------------------------------------------------------------
   // Configuration port. Every write transfer is taken at once.
   // ------------------------------------------------------------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff    <= XW'(fscpa_pkg::eff_dim(DIM_RESET, MAX_WIDTH));
         cfg_h_ff    <= YW'(fscpa_pkg::eff_dim(DIM_RESET, MAX_HEIGHT));
         cfg_mode_ff <= fscpa_pkg::MODE_GRAY;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            fscpa_pkg::CSR_IMAGE_WIDTH: begin
               cfg_w_ff <= XW'(fscpa_pkg::eff_dim(csr_ch.data, MAX_WIDTH));
            end
            fscpa_pkg::CSR_IMAGE_HEIGHT: begin
               cfg_h_ff <= YW'(fscpa_pkg::eff_dim(csr_ch.data, MAX_HEIGHT));
            end
            fscpa_pkg::CSR_COLOR_MODE: begin
               cfg_mode_ff <= fscpa_pkg::color_mode_type'(csr_ch.data[0]);
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow. A stage moves on when it is empty or when the stage
   // after it moves on, so bubbles are squeezed out while the output waits.
   // ------------------------------------------------------------------
   always_comb begin
      adv[NST-1] = !v_ff[NST-1] || rsp_ch.ready;
      for (int i = NST - 2; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
      v_in[0] = adv[0] ? req_ch.valid : v_ff[0];
      for (int i = 1; i < NST; i++) begin
         v_in[i] = adv[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ch.ready = adv[0];

   // ------------------------------------------------------------------
   // Stage 0: capture the request transfer.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_op_ff <= req_ch.opcode;
         s0_x_ff  <= req_ch.x_coord;
         s0_y_ff  <= req_ch.y_coord;
         s0_r_ff  <= req_ch.write_red;
         s0_g_ff  <= req_ch.write_green;
         s0_b_ff  <= req_ch.write_blue;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: clamp each coordinate to the image and flag when it moved.
   // ------------------------------------------------------------------
   always_comb begin
      logic x_neg, x_big, y_neg, y_big;
      x_neg = s0_x_ff[fscpa_pkg::COORD_W-1];
      y_neg = s0_y_ff[fscpa_pkg::COORD_W-1];
      x_big = !x_neg && ({1'b0, s0_x_ff} >= CMPW'(cfg_w_ff));
      y_big = !y_neg && ({1'b0, s0_y_ff} >= CMPW'(cfg_h_ff));
      if (x_neg) begin
         s1_cx_in = '0;
      end else if (x_big) begin
         s1_cx_in = CXW'(cfg_w_ff - XW'(1));
      end else begin
         s1_cx_in = CXW'(s0_x_ff);
      end
      if (y_neg) begin
         s1_cy_in = '0;
      end else if (y_big) begin
         s1_cy_in = CYW'(cfg_h_ff - YW'(1));
      end else begin
         s1_cy_in = CYW'(s0_y_ff);
      end
      s1_out_in = x_neg || x_big || y_neg || y_big;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_op_ff      <= s0_op_ff;
         s1_out_ff     <= s1_out_in;
         s1_cx_ff      <= s1_cx_in;
         s1_cy_ff      <= s1_cy_in;
         s1_byte_ff[0] <= fscpa_pkg::sat_byte(s0_r_ff);
         s1_byte_ff[1] <= fscpa_pkg::sat_byte(s0_g_ff);
         s1_byte_ff[2] <= fscpa_pkg::sat_byte(s0_b_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: pixel index cx + cy * width.
   // ------------------------------------------------------------------
   assign s1_prod   = PW'(s1_cy_ff) * PW'(cfg_w_ff);
   assign s2_adr_in = ADR_W'(s1_prod + PW'(s1_cx_ff));

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_op_ff   <= s1_op_ff;
         s2_out_ff  <= s1_out_ff;
         s2_adr_ff  <= s2_adr_in;
         s2_byte_ff <= s1_byte_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: a gray byte lives at byte address adr, which is bank adr mod 3
   // at row adr / 3. The remainder only needs the low two bits of adr - 3q.
   // ------------------------------------------------------------------
   assign s2_qprod  = QPW'(s2_adr_ff) * QPW'(RECIP);
   assign s3_row_in = ADR_W'(s2_qprod >> RECIP_SHIFT);
   assign s3_rem_in = 2'({2'b00, s2_adr_ff} - ({2'b00, s3_row_in} + {1'b0, s3_row_in, 1'b0}));

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_op_ff   <= s2_op_ff;
         s3_out_ff  <= s2_out_ff;
         s3_adr_ff  <= s2_adr_ff;
         s3_row_ff  <= s3_row_in;
         s3_rem_ff  <= s3_rem_in;
         s3_byte_ff <= s2_byte_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: memory access. In RGB mode the pixel's three bytes sit at row
   // adr of banks 0, 1 and 2; in gray mode one bank holds the byte.
   // ------------------------------------------------------------------
   always_comb begin
      logic store;
      store     = v_ff[3] && adv[4] && (s3_op_ff == fscpa_pkg::OP_WRITE) && !s3_out_ff;
      bank_re   = v_ff[3] && adv[4] && (s3_op_ff == fscpa_pkg::OP_READ);
      bank_addr = (cfg_mode_ff == fscpa_pkg::MODE_RGB) ? s3_adr_ff : s3_row_ff;
      for (int k = 0; k < NB; k++) begin
         if (cfg_mode_ff == fscpa_pkg::MODE_RGB) begin
            bank_we[k]    = store;
            bank_wdata[k] = s3_byte_ff[k];
         end else begin
            bank_we[k]    = store && (s3_rem_ff == 2'(k));
            bank_wdata[k] = s3_byte_ff[0];
         end
      end
   end

   for (genvar k = 0; k < NB; k++) begin : g_bank
      fscpa_ram #(
         .DEPTH (DEPTH)
      ) u_bank (
         .clock (clock),
         .wr_en (bank_we[k]),
         .rd_en (bank_re),
         .addr  (bank_addr),
         .wdata (bank_wdata[k]),
         .rdata (bank_rdata[k])
      );
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_op_ff  <= s3_op_ff;
         s4_out_ff <= s3_out_ff;
         s4_rem_ff <= s3_rem_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: arrange the channels. A write answers with zero bytes.
   // ------------------------------------------------------------------
   always_comb begin
      logic [CW-1:0] gray;
      case (s4_rem_ff)
         2'd1:    gray = bank_rdata[1];
         2'd2:    gray = bank_rdata[2];
         default: gray = bank_rdata[0];
      endcase
      for (int k = 0; k < NB; k++) begin
         if (s4_op_ff == fscpa_pkg::OP_WRITE) begin
            rsp_byte_in[k] = '0;
         end else if (cfg_mode_ff == fscpa_pkg::MODE_RGB) begin
            rsp_byte_in[k] = bank_rdata[k];
         end else begin
            rsp_byte_in[k] = gray;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         rsp_status_ff <= s4_out_ff;
         rsp_byte_ff   <= rsp_byte_in;
      end
   end

   assign rsp_ch.valid      = v_ff[NST-1];
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.read_red   = rsp_byte_ff[0];
   assign rsp_ch.read_green = rsp_byte_ff[1];
   assign rsp_ch.read_blue  = rsp_byte_ff[2];

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // The reciprocal split of the byte address never yields a remainder of three.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] |-> (s3_rem_ff != 2'd3))
      else $error("byte address split gave an impossible bank");

   // A gray write lands in exactly one bank.
   a_gray_one_bank: assert property (@(posedge clock) disable iff (reset)
      (v_ff[3] && adv[4] && (s3_op_ff == fscpa_pkg::OP_WRITE) && !s3_out_ff &&
       (cfg_mode_ff == fscpa_pkg::MODE_GRAY)) |-> $onehot(bank_we))
      else $error("gray write did not select exactly one bank");

   // A write whose coordinates fell outside the image leaves the store alone.
   a_clamped_write_dropped: assert property (@(posedge clock) disable iff (reset)
      (v_ff[3] && s3_out_ff) |-> (bank_we == '0))
      else $error("write outside the image reached the store");

   // The pipeline is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (v_ff == '0))
      else $error("pipeline holds an item after reset");

endmodule

### bench/frame_store_clamped_pixel_access_checker.sv
`timescale 1ns / 100ps

module frame_store_clamped_pixel_access_checker
   import fscpa_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic  clock,
   input  logic  reset,
   fscpa_req_if  req_ch,
   fscpa_rsp_if  rsp_ch,
   fscpa_csr_if  csr_ch,
   output int    error_count,
   output int    pending
);

   localparam int STORE_BYTES = MAX_WIDTH * MAX_HEIGHT * BYTES_PER_RGB;

   typedef struct packed {
      logic              status;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_result_type;

   // Mirror of the frame store and of the registers.
   logic [CHAN_W-1:0]     frame_mirror [0:STORE_BYTES-1];
   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;
   color_mode_type        mode_reg;
   pixel_result_type      expected_pixels[$];

   function automatic int bounded_dim(input logic [CSR_DATA_W-1:0] v, input int limit);
      if (v == 0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic logic [CHAN_W-1:0] clip_byte(input logic signed [COORD_W-1:0] v);
      if (v < 0) return '0;
      if (v > 255) return 8'hFF;
      return v[CHAN_W-1:0];
   endfunction

   // Clamps the coordinates, updates the mirror on a write inside the
   // image and returns what the block must answer.
   function automatic pixel_result_type pixel_access(
      input opcode_type                 op,
      input logic signed [COORD_W-1:0]  x,
      input logic signed [COORD_W-1:0]  y,
      input logic signed [COORD_W-1:0]  r,
      input logic signed [COORD_W-1:0]  g,
      input logic signed [COORD_W-1:0]  b);
      pixel_result_type res;
      int w, h, cx, cy, pix, base;
      logic outside;
      w = bounded_dim(width_reg, MAX_WIDTH);
      h = bounded_dim(height_reg, MAX_HEIGHT);
      outside = 1'b0;
      if (int'(x) < 0) begin
         cx = 0;
         outside = 1'b1;
      end else if (int'(x) >= w) begin
         cx = w - 1;
         outside = 1'b1;
      end else begin
         cx = int'(x);
      end
      if (int'(y) < 0) begin
         cy = 0;
         outside = 1'b1;
      end else if (int'(y) >= h) begin
         cy = h - 1;
         outside = 1'b1;
      end else begin
         cy = int'(y);
      end
      pix  = cx + cy * w;
      base = pix * BYTES_PER_RGB;
      res  = '0;
      res.status = outside;
      if (op == OP_WRITE) begin
         if (!outside) begin
            if (mode_reg == MODE_GRAY) begin
               frame_mirror[pix] = clip_byte(r);
            end else begin
               frame_mirror[base]     = clip_byte(r);
               frame_mirror[base + 1] = clip_byte(g);
               frame_mirror[base + 2] = clip_byte(b);
            end
         end
      end else if (mode_reg == MODE_GRAY) begin
         res.red   = frame_mirror[pix];
         res.green = frame_mirror[pix];
         res.blue  = frame_mirror[pix];
      end else begin
         res.red   = frame_mirror[base];
         res.green = frame_mirror[base + 1];
         res.blue  = frame_mirror[base + 2];
      end
      return res;
   endfunction

   task automatic compare_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         width_reg  = 9'd256;
         height_reg = 9'd256;
         mode_reg   = MODE_GRAY;
         expected_pixels.delete();
      end else begin
         // Results are in order, so the oldest expectation is the one to match.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %b/%0d/%0d/%0d",
                        $time, rsp_ch.status, rsp_ch.read_red, rsp_ch.read_green,
                        rsp_ch.read_blue);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               compare_field("status", want.status, rsp_ch.status);
               compare_field("read_red", want.red, rsp_ch.read_red);
               compare_field("read_green", want.green, rsp_ch.read_green);
               compare_field("read_blue", want.blue, rsp_ch.read_blue);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_pixels.push_back(pixel_access(req_ch.opcode, req_ch.x_coord,
               req_ch.y_coord, req_ch.write_red, req_ch.write_green, req_ch.write_blue));
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_index_type'(csr_ch.index))
               CSR_IMAGE_WIDTH:  width_reg  = csr_ch.data;
               CSR_IMAGE_HEIGHT: height_reg = csr_ch.data;
               CSR_COLOR_MODE:   mode_reg   = color_mode_type'(csr_ch.data[0]);
               default: ;
            endcase
         end
      end
      pending = expected_pixels.size();
   end

endmodule

### bench/frame_store_clamped_pixel_access_test.sv
`timescale 1ns / 100ps

module frame_store_clamped_pixel_access_test;
   import fscpa_pkg::*;

   localparam int STORE_BYTES     = MAX_WIDTH_DEF * MAX_HEIGHT_DEF * BYTES_PER_RGB;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 127;
   // The pipeline is six stages deep; the settle wait gives margin beyond it.
   localparam int SETTLE_CYCLES   = 12;
   localparam int DRAIN_LIMIT     = 100000;

   typedef struct {
      int x;
      int y;
   } pixel_spot_type;

   logic clock;
   logic reset;
   int   error_count;
   int   pending;

   fscpa_req_if req_ch ();
   fscpa_rsp_if rsp_ch ();
   fscpa_csr_if csr_ch ();

   frame_store_clamped_pixel_access dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   frame_store_clamped_pixel_access_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .error_count (error_count),
      .pending     (pending)
   );

   // Register settings of the random phases. They include the smallest and
   // largest images, a zero size (which acts as one) and sizes above the
   // maximum (which saturate).
   int plan_width  [PHASES] = '{256, 1, 1, 7, 0, 511, 256, 1, 13, 16, 3, 100};
   int plan_height [PHASES] = '{256, 1, 1, 5, 0, 300, 1, 256, 9, 16, 200, 2};
   int plan_mode   [PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0};

   // Stimulus bookkeeping. The store is not cleared by reset, so a read may
   // only land on bytes that some earlier write has filled. The bench tracks
   // which bytes hold data and, for the current setting, which pixels were
   // written, so that reads can be aimed at them.
   bit             byte_done [0:STORE_BYTES-1];
   pixel_spot_type filled_spots[$];
   int             eff_w;
   int             eff_h;
   color_mode_type cur_mode;
   int             idle_pct;
   int             stall_pct;
   bit             drained;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous bound on the whole run; a correct run needs a small fraction.
   initial begin
      #5_000_000;
      $display("frame_store_clamped_pixel_access_test: errors");
      $finish;
   end

   // The result side stalls at random, at a rate set by the current phase.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic int clamp_coord(input int v, input int dim);
      if (v < 0) return 0;
      if (v >= dim) return dim - 1;
      return v;
   endfunction

   // True when every byte that a read at (x, y) would return has been written.
   function automatic bit covered(input int x, input int y);
      int pix;
      pix = clamp_coord(x, eff_w) + clamp_coord(y, eff_h) * eff_w;
      if (cur_mode == MODE_GRAY) return byte_done[pix];
      return byte_done[3 * pix] && byte_done[3 * pix + 1] && byte_done[3 * pix + 2];
   endfunction

   // Coordinates: mostly inside and near the origin so that reads find data,
   // with edges, near misses and the full signed range mixed in.
   function automatic int pick_coord(input int dim);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) return $signed(16'($urandom));
      if (sel < 25) begin
         if ($urandom_range(0, 1)) return -int'($urandom_range(1, 3));
         return dim - 1 + int'($urandom_range(1, 3));
      end
      if (sel < 45) return $urandom_range(0, 1) ? 0 : dim - 1;
      if (sel < 75) return $urandom_range(0, (dim > 16) ? 15 : dim - 1);
      return $urandom_range(0, dim - 1);
   endfunction

   // Channel values: mostly in range, some just beyond it on either side and
   // some anywhere in the signed range, so that saturation is exercised.
   function automatic int pick_level();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 15) return $signed(16'($urandom));
      if (sel < 25) return -int'($urandom_range(1, 300));
      if (sel < 35) return $urandom_range(256, 600);
      return $urandom_range(0, 255);
   endfunction

   // One transfer on the request channel, preceded by random idle cycles.
   task automatic transfer(input opcode_type op, input int x, input int y,
                           input int r, input int g, input int b);
      int pix;
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.opcode      = op;
      req_ch.x_coord     = 16'(x);
      req_ch.y_coord     = 16'(y);
      req_ch.write_red   = 16'(r);
      req_ch.write_green = 16'(g);
      req_ch.write_blue  = 16'(b);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // A write inside the image fills its bytes under the current layout.
      if (op == OP_WRITE && x >= 0 && x < eff_w && y >= 0 && y < eff_h) begin
         pix = x + y * eff_w;
         if (cur_mode == MODE_GRAY) begin
            byte_done[pix] = 1'b1;
         end else begin
            byte_done[3 * pix]     = 1'b1;
            byte_done[3 * pix + 1] = 1'b1;
            byte_done[3 * pix + 2] = 1'b1;
         end
         filled_spots.push_back('{x, y});
      end
   endtask

   // Lowers valid, waits until every expected result has come back and lets
   // the pipeline settle. Flags a block that never drains.
   task automatic wait_drained();
      int spent;
      spent = 0;
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending != 0 && spent < DRAIN_LIMIT) begin
         @(negedge clock);
         spent++;
      end
      if (pending != 0) drained = 1'b0;
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes one register and follows the new image geometry and layout.
   task automatic set_register(input csr_index_type idx, input int value);
      int v;
      v = value & 9'h1FF;
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = CSR_DATA_W'(v);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid = 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  eff_w = (v == 0) ? 1 : ((v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : v);
         CSR_IMAGE_HEIGHT: eff_h = (v == 0) ? 1 : ((v > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : v);
         CSR_COLOR_MODE:   cur_mode = color_mode_type'(v[0]);
         default: ;
      endcase
      // Pixel positions of earlier settings no longer map the same way.
      filled_spots.delete();
   endtask

   // One random access. Reads that would hit unwritten bytes are redirected
   // to a written pixel, often through coordinates far outside that clamp
   // onto it when it sits on an edge.
   task automatic random_item();
      int x, y;
      pixel_spot_type spot;
      if ($urandom_range(0, 99) < 45 || filled_spots.size() == 0) begin
         transfer(OP_WRITE, pick_coord(eff_w), pick_coord(eff_h),
                  pick_level(), pick_level(), pick_level());
      end else begin
         x = pick_coord(eff_w);
         y = pick_coord(eff_h);
         if (!covered(x, y)) begin
            spot = filled_spots[$urandom_range(0, filled_spots.size() - 1)];
            x = spot.x;
            y = spot.y;
            if (x == 0 && $urandom_range(0, 1)) begin
               x = -int'($urandom_range(1, 32768));
            end else if (x == eff_w - 1 && $urandom_range(0, 1)) begin
               x = $urandom_range(eff_w, 32767);
            end
            if (y == 0 && $urandom_range(0, 1)) begin
               y = -int'($urandom_range(1, 32768));
            end else if (y == eff_h - 1 && $urandom_range(0, 1)) begin
               y = $urandom_range(eff_h, 32767);
            end
         end
         // The write fields are ignored on a read, so they carry noise.
         transfer(OP_READ, x, y, $signed(16'($urandom)), $signed(16'($urandom)),
                  $signed(16'($urandom)));
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_READ;
      req_ch.x_coord     = '0;
      req_ch.y_coord     = '0;
      req_ch.write_red   = '0;
      req_ch.write_green = '0;
      req_ch.write_blue  = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = CSR_IMAGE_WIDTH;
      csr_ch.data        = '0;
      eff_w              = MAX_WIDTH_DEF;
      eff_h              = MAX_HEIGHT_DEF;
      cur_mode           = MODE_GRAY;
      idle_pct           = 0;
      stall_pct          = 0;
      drained            = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed part on the reset setting, a 256 by 256 gray image. The
      // corners are written with values beyond both byte limits.
      transfer(OP_WRITE, 0, 0, -32768, 0, 0);
      transfer(OP_WRITE, 255, 255, 32767, 0, 0);
      transfer(OP_WRITE, 255, 0, 256, 0, 0);
      transfer(OP_WRITE, 0, 255, -1, 0, 0);
      transfer(OP_WRITE, 1, 0, 255, 0, 0);
      transfer(OP_WRITE, 2, 0, 128, 0, 0);
      transfer(OP_WRITE, 5, 5, 100, -32768, 32767);
      // Reads at the extremes of both coordinates clamp onto the corners.
      transfer(OP_READ, -32768, -32768, 0, 0, 0);
      transfer(OP_READ, 32767, 32767, 0, 0, 0);
      transfer(OP_READ, 32767, -7, 0, 0, 0);
      transfer(OP_READ, -1, 300, 0, 0, 0);
      transfer(OP_READ, 5, 5, 0, 0, 0);
      // Writes that miss the image on each side are dropped.
      transfer(OP_WRITE, 256, 0, 77, 77, 77);
      transfer(OP_WRITE, -1, 3, 77, 77, 77);
      transfer(OP_WRITE, 0, 32767, 77, 77, 77);
      transfer(OP_WRITE, 5, -32768, 77, 77, 77);
      transfer(OP_READ, 0, 0, 0, 0, 0);

      // Switching to RGB keeps the bytes: pixel (0, 0) now reads the three
      // gray bytes written at (0, 0), (1, 0) and (2, 0).
      wait_drained();
      set_register(CSR_COLOR_MODE, MODE_RGB);
      transfer(OP_READ, 0, 0, 0, 0, 0);
      transfer(OP_WRITE, 10, 10, -32768, 32767, 200);
      transfer(OP_READ, 10, 10, 0, 0, 0);
      transfer(OP_WRITE, 255, 255, 300, -5, 255);
      transfer(OP_READ, 300, 1000, 0, 0, 0);
      transfer(OP_WRITE, -3, -3, 1, 2, 3);

      // Random phases: each one rewrites all registers while the block is
      // idle and then runs with its own pattern of idle and stall cycles.
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         set_register(CSR_IMAGE_WIDTH, plan_width[p]);
         set_register(CSR_IMAGE_HEIGHT, plan_height[p]);
         set_register(CSR_COLOR_MODE, plan_mode[p]);
         case (p % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 72;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 72;
            end
            default: begin
               idle_pct  = 17;
               stall_pct = 17;
            end
         endcase
         repeat (ITEMS_PER_PHASE) random_item();
      end

      wait_drained();
      if (error_count == 0 && drained) begin
         $display("frame_store_clamped_pixel_access_test: clean");
      end else begin
         $display("frame_store_clamped_pixel_access_test: errors");
      end
      $finish;
   end

endmodule
